// ===== hw/rtl/ccw_pkg.sv =====
// Shared constants for the coin change way counter.
// No dependencies; used by ccw_mod_add and the top level in hw/rtl.
package ccw_pkg;

    localparam int unsigned WAY_W          = 30;
    localparam int unsigned COIN_W         = 10;
    localparam int unsigned CFG_W          = 10;
    localparam int unsigned S_TDATA_W      = 16;
    localparam int unsigned M_TDATA_W      = 32;
    localparam int unsigned MAX_AMOUNT_DEF = 1023;

    localparam logic [WAY_W-1:0] WAY_MOD = WAY_W'(1000000007);

endpackage

// ===== hw/rtl/ccw_mod_add.sv =====
// Shared modular adder: (a + b) mod WAY_MOD for operands already below the modulus.
// Depends on ccw_pkg.
module ccw_mod_add (
    input  logic [ccw_pkg::WAY_W-1:0] a,
    input  logic [ccw_pkg::WAY_W-1:0] b,
    output logic [ccw_pkg::WAY_W-1:0] sum
);

    logic [ccw_pkg::WAY_W:0] raw;
    logic [ccw_pkg::WAY_W:0] red;

    always_comb begin
        raw = {1'b0, a} + {1'b0, b};
        red = raw - {1'b0, ccw_pkg::WAY_MOD};
        if (raw >= {1'b0, ccw_pkg::WAY_MOD}) begin
            sum = red[ccw_pkg::WAY_W-1:0];
        end else begin
            sum = raw[ccw_pkg::WAY_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/ccw_way_ram.sv =====
// Way table storage: one write port, two registered read ports.
// Read during write to the same address returns the old contents.
// No dependencies; instantiated by the top level.
module ccw_way_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10,
    parameter int unsigned DW    = 30
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== hw/rtl/coin_change_way_counter_core.sv =====
// Coin change way counter, top level: sequencer, config register, output register.
// Depends on ccw_pkg, ccw_way_ram, ccw_mod_add.
//
//  channel  | ports                          | payload
//  ---------+--------------------------------+----------------------------------
//  coin in  | s_tvalid s_tready s_tdata      | s_tdata[9:0] coin_value,
//           | s_tlast                        | s_tlast last_coin
//  count out| m_tvalid m_tready m_tdata      | m_tdata[29:0] way_count
//  config   | cfg_we cfg_wdata               | cfg_wdata[9:0] target_amount
//
// A coin in 1..target walks the table one entry per cycle through the shared
// modular adder; zero or oversize coins leave the table unchanged. A last coin
// then reads the count (S_RD, S_CAP) and runs a clearing pass over entries 0..hwm
// (hwm = highest target used in the problem). After reset a clearing pass over
// all MAX_AMOUNT + 1 entries runs before the first coin is taken.
// s_tready is low while busy; a waiting result only stalls the next read-out.
module coin_change_way_counter_core #(
    parameter int unsigned MAX_AMOUNT = ccw_pkg::MAX_AMOUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ccw_pkg::CFG_W-1:0]       cfg_wdata,   // target_amount
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ccw_pkg::S_TDATA_W-1:0]   s_tdata,     // [9:0] coin_value
    input  logic                            s_tlast,     // last_coin
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ccw_pkg::M_TDATA_W-1:0]   m_tdata      // [29:0] way_count
);

    localparam int unsigned DEPTH = MAX_AMOUNT + 1;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = (AW > ccw_pkg::CFG_W) ? AW : ccw_pkg::CFG_W;
    localparam int unsigned WW    = ccw_pkg::WAY_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CAP   = 3'd4;

    logic [2:0]                 state_reg, state_next;
    logic [ccw_pkg::CFG_W-1:0]  target_reg;
    logic [AW-1:0]              coin_reg, coin_next;
    logic                       last_reg, last_next;
    logic [AW:0]                rd_j_reg, rd_j_next;
    logic [AW-1:0]              wj_reg, wj_next;
    logic                       pv_reg, pv_next;
    logic                       fwd_hit_reg, fwd_hit_next;
    logic [WW-1:0]              fwd_data_reg;
    logic [AW-1:0]              hwm_reg, hwm_next;
    logic [AW:0]                clr_reg, clr_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [WW-1:0]              m_data_reg;

    logic [CW-1:0]  tgt_wide;
    logic [AW-1:0]  tgt;
    logic [CW-1:0]  coin_wide;
    logic           coin_skip;
    logic           in_xfer;
    logic           issuing;
    logic           out_load;
    logic [AW:0]    b_addr_full;

    logic           we;
    logic [AW-1:0]  waddr;
    logic [WW-1:0]  wdata;
    logic [AW-1:0]  raddr_a, raddr_b;
    logic [WW-1:0]  rdata_a, rdata_b;
    logic [WW-1:0]  b_val;
    logic [WW-1:0]  sum;

    ccw_way_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (WW)
    ) u_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    ccw_mod_add u_add (
        .a   (rdata_a),
        .b   (b_val),
        .sum (sum)
    );

    // Effective target, clamped to the last table entry (MAX_AMOUNT)
    always_comb begin
        tgt_wide  = CW'(target_reg);
        coin_wide = CW'(s_tdata[ccw_pkg::COIN_W-1:0]);
        if (tgt_wide > CW'(MAX_AMOUNT)) begin
            tgt = AW'(MAX_AMOUNT);
        end else begin
            tgt = tgt_wide[AW-1:0];
        end
        coin_skip = (coin_wide == '0) || (coin_wide > CW'(tgt));
    end

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign issuing  = (state_reg == S_RUN) && (rd_j_reg <= {1'b0, tgt});
    assign out_load = (state_reg == S_CAP) && (!m_tvalid_reg || m_tready);

    // Entry just written may be read as j - coin in the same cycle (coin of 1)
    assign b_val = fwd_hit_reg ? fwd_data_reg : rdata_b;

    always_comb begin
        b_addr_full = rd_j_reg - {1'b0, coin_reg};
        raddr_b     = b_addr_full[AW-1:0];
        if (state_reg == S_RUN) begin
            raddr_a = rd_j_reg[AW-1:0];
        end else begin
            raddr_a = tgt;
        end

        if (state_reg == S_CLEAR) begin
            we    = 1'b1;
            waddr = clr_reg[AW-1:0];
            wdata = (clr_reg == '0) ? WW'(1) : '0;
        end else begin
            we    = pv_reg;
            waddr = wj_reg;
            wdata = sum;
        end
    end

    always_comb begin
        state_next    = state_reg;
        coin_next     = coin_reg;
        last_next     = last_reg;
        rd_j_next     = rd_j_reg;
        wj_next       = wj_reg;
        pv_next       = 1'b0;
        fwd_hit_next  = 1'b0;
        hwm_next      = hwm_reg;
        clr_next      = clr_reg;
        m_tvalid_next = m_tvalid_reg;

        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg[AW-1:0] == hwm_reg) begin
                    clr_next   = '0;
                    hwm_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    last_next = s_tlast;
                    if (coin_skip) begin
                        state_next = s_tlast ? S_RD : S_IDLE;
                    end else begin
                        coin_next  = coin_wide[AW-1:0];
                        rd_j_next  = {1'b0, coin_wide[AW-1:0]};
                        if (tgt > hwm_reg) begin
                            hwm_next = tgt;
                        end
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (issuing) begin
                    pv_next      = 1'b1;
                    wj_next      = rd_j_reg[AW-1:0];
                    rd_j_next    = rd_j_reg + 1'b1;
                    fwd_hit_next = pv_reg && (raddr_b == wj_reg);
                end else if (!pv_reg) begin
                    state_next = last_reg ? S_RD : S_IDLE;
                end
            end
            S_RD: begin
                state_next = S_CAP;
            end
            S_CAP: begin
                if (out_load) begin
                    state_next = S_CLEAR;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            target_reg   <= '0;
            pv_reg       <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            hwm_reg      <= AW'(MAX_AMOUNT);
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            last_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            if (cfg_we) begin
                target_reg <= cfg_wdata;
            end
            pv_reg       <= pv_next;
            fwd_hit_reg  <= fwd_hit_next;
            hwm_reg      <= hwm_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        coin_reg     <= coin_next;
        rd_j_reg     <= rd_j_next;
        wj_reg       <= wj_next;
        fwd_data_reg <= wdata;
        if (out_load) begin
            m_data_reg <= rdata_a;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = ccw_pkg::M_TDATA_W'(m_data_reg);

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[ccw_pkg::WAY_W-1:0] < ccw_pkg::WAY_MOD))
        else $error("way count not reduced");

    a_write_below_hwm: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN && pv_reg) |-> (wj_reg <= hwm_reg && wj_reg <= tgt))
        else $error("table write beyond high-water mark");

    a_cap_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CAP && m_tvalid && !m_tready) |=> (state_reg == S_CAP))
        else $error("result read-out overran pending output");

    a_fwd_only_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> (pv_reg && $past(pv_reg)))
        else $error("bypass hit outside table walk");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for coin_change_way_counter_core: streams coin sets,
// predicts each way count in a scoreboard class and checks every count transfer.
// Depends on ccw_pkg and the RTL in hw/rtl.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ccw_pkg::*;

    localparam int unsigned MAX_AMT       = MAX_AMOUNT_DEF;
    // a full coin walk plus read-out plus a full clearing pass, with margin
    localparam int unsigned SETTLE_CYCLES = 2 * (MAX_AMT + 1) + 64;
    localparam int unsigned CYCLE_LIMIT   = 4_000_000;
    localparam int unsigned NUM_PHASES    = 12;
    localparam int unsigned PHASE_COINS   = 45;

    class way_count_scoreboard;
        logic [WAY_W-1:0] ways [0:MAX_AMT];
        logic [CFG_W-1:0] target;
        logic [WAY_W-1:0] pending_counts [$];
        int unsigned      mismatches;

        function new();
            target     = '0;
            mismatches = 0;
            clear_ways();
        endfunction

        function void clear_ways();
            foreach (ways[j]) ways[j] = '0;
            ways[0] = WAY_W'(1);
        endfunction

        function void set_target(logic [CFG_W-1:0] t);
            target = t;
        endfunction

        function void note_coin(logic [COIN_W-1:0] coin, logic last);
            int unsigned t;
            int unsigned s;
            t = (target > MAX_AMT) ? MAX_AMT : target;
            if (coin != 0 && coin <= t) begin
                for (int unsigned j = coin; j <= t; j++) begin
                    s = ways[j] + ways[j - coin];
                    if (s >= WAY_MOD)
                        s -= WAY_MOD;
                    ways[j] = s[WAY_W-1:0];
                end
            end
            if (last) begin
                pending_counts.push_back(ways[t]);
                clear_ways();
            end
        endfunction

        function void check_count(logic [WAY_W-1:0] got);
            logic [WAY_W-1:0] want;
            if (pending_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected way_count transfer: got %0d", got);
            end else begin
                want = pending_counts.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("way_count mismatch: expected %0d, got %0d", want, got);
                end
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;    // [9:0] coin_value
    logic                   s_tlast   = 1'b0;  // last_coin
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;           // [29:0] way_count

    way_count_scoreboard board;
    bit          quiet       = 1'b0;
    bit          src_bursty  = 1'b1;
    bit          sink_bursty = 1'b1;
    int unsigned cycles      = 0;

    coin_change_way_counter_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_count(m_tdata[WAY_W-1:0]);
    end

    // result side: random stall bursts
    initial begin : count_sink
        int unsigned stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if (sink_bursty && !quiet && $urandom_range(0, 5) == 0)
                    stall = $urandom_range(1, 11);
            end
        end
    end

    function automatic int unsigned coin_gap();
        if (quiet || !src_bursty || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 11);
    endfunction

    function automatic logic [COIN_W-1:0] pick_coin(int unsigned t);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1 || t == 0)
            return COIN_W'($urandom_range(0, 1023));
        if (r == 2)
            return (t < 1023) ? COIN_W'($urandom_range(t + 1, 1023)) : COIN_W'(1023);
        // small coins drive the counts past the modulus on big targets
        if (r < 6)
            return COIN_W'($urandom_range(1, (t < 8) ? t : 8));
        return COIN_W'($urandom_range(1, t));
    endfunction

    task automatic send_coin(input logic [COIN_W-1:0] coin, input logic last);
        int unsigned gap;
        gap = coin_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(coin);
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        board.note_coin(coin, last);
    endtask

    // block must be idle: drain counts, then let any walk or clearing pass finish
    task automatic write_target(input logic [CFG_W-1:0] t);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending_counts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= t;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        board.set_target(t);
    endtask

    initial begin : stimulus
        int unsigned t;
        int unsigned n;
        int unsigned len;
        board = new();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // target zero: empty set counts one way, oversize coin changes nothing
        write_target(CFG_W'(0));
        send_coin(COIN_W'(0), 1'b1);
        send_coin(10'h3FF, 1'b1);

        // largest target, small coins: counts wrap the modulus
        write_target(CFG_W'(1023));
        for (int unsigned c = 1; c <= 8; c++)
            send_coin(COIN_W'(c), 1'b0);
        send_coin(10'd1023, 1'b1);

        // last flag alone, oversize coin, and a last coin that counts itself
        write_target(CFG_W'(7));
        send_coin(COIN_W'(0), 1'b1);
        send_coin(COIN_W'(9), 1'b1);
        send_coin(COIN_W'(7), 1'b1);

        // target changed in the middle of a set
        write_target(CFG_W'(10));
        send_coin(COIN_W'(3), 1'b0);
        write_target(CFG_W'(20));
        send_coin(COIN_W'(7), 1'b0);
        send_coin(COIN_W'(0), 1'b1);

        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            quiet       = (p == NUM_PHASES - 1);
            src_bursty  = ($urandom_range(0, 3) != 0);
            sink_bursty = ($urandom_range(0, 3) != 0);
            if (p % 5 == 3)
                t = $urandom_range(600, 1023);
            else
                t = $urandom_range(0, 48);
            write_target(CFG_W'(t));
            n = 0;
            while (n < PHASE_COINS) begin
                len = $urandom_range(1, 6);
                for (int unsigned k = 0; k < len; k++) begin
                    send_coin(pick_coin(t), k == len - 1);
                    n++;
                end
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending_counts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.pending_counts.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
